// ===== hdl/rmq_pkg.sv =====
package rmq_pkg;

  // Default fixed-point format: signed Q2.30 in a 32-bit word.
  localparam int unsigned WordBitsDef = 32;
  localparam int unsigned FracBitsDef = 30;

  // Branch codes reported with every result.
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

endpackage

// ===== hdl/rmq_if.sv =====
// Input channel: one request carries the nine matrix entries.
interface rmq_in_if #(
  parameter int unsigned W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] row0_col0;
  logic signed [W-1:0] row0_col1;
  logic signed [W-1:0] row0_col2;
  logic signed [W-1:0] row1_col0;
  logic signed [W-1:0] row1_col1;
  logic signed [W-1:0] row1_col2;
  logic signed [W-1:0] row2_col0;
  logic signed [W-1:0] row2_col1;
  logic signed [W-1:0] row2_col2;

  modport source (
    output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
           row2_col0, row2_col1, row2_col2,
    input  ready
  );
  modport sink (
    input  valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
           row2_col0, row2_col1, row2_col2,
    output ready
  );
endinterface

// Output channel: one request carries the quaternion and its status.
interface rmq_out_if #(
  parameter int unsigned W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_w;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;
  logic [1:0]          branch_taken;
  logic                degenerate;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate,
    output ready
  );
endinterface

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// The square-root pipeline computes one root bit per stage and the divider one quotient bit
// per stage. Throughput: one matrix per cycle; the whole pipeline advances whenever the
// output register is empty or its result is being taken.
// Reset: rst_ni clears all valid bits asynchronously; data registers are not reset.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int unsigned WORD_BITS = WordBitsDef,
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  rmq_in_if.sink      in_i,
  rmq_out_if.source   out_o
);

  localparam int unsigned W    = WORD_BITS;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned RB   = ((W > F + 1) ? W : F + 1) + 3;
  localparam int unsigned RADW = RB - 1;
  localparam int unsigned NB   = RADW + F;
  localparam int unsigned SQI  = NB + (NB % 2);
  localparam int unsigned R    = SQI / 2;
  localparam int unsigned NUMW = W + 1;
  localparam int unsigned N    = NUMW + F;
  localparam int unsigned D    = R + 1;
  localparam int unsigned SQSD = 2 + 3 * NUMW;
  localparam int unsigned DVSD = R + 2 + 3 + 3;
  localparam int unsigned CW   = ((R > W) ? R : W) + 1;

  localparam logic [W-1:0] WMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMin = {1'b1, {(W-1){1'b0}}};

  logic en;

  // Front stage.
  logic                   fr_valid;
  logic [1:0]             fr_branch;
  logic [RADW-1:0]        fr_rad;
  logic signed [NUMW-1:0] fr_num [3];

  // Square-root pipeline.
  logic [SQI-1:0]  sq_rad;
  logic [SQSD-1:0] sq_side_in, sq_side_out;
  logic            sq_valid;
  logic [R-1:0]    sq_root;

  // Divider preparation stage.
  logic                 pp_valid_q;
  logic [R-1:0]         pp_root_q;
  logic [1:0]           pp_branch_q;
  logic [2:0]           pp_neg_q, pp_nz_q;
  logic [N-1:0]         pp_dvd_q [3];
  logic signed [NUMW-1:0] sq_num [3];
  logic [1:0]           sq_branch;

  // Divider.
  logic            dv_valid;
  logic [N-1:0]    dv_quot [3];
  logic [DVSD-1:0] dv_side;
  logic [R-1:0]    dv_root;
  logic [1:0]      dv_branch;
  logic [2:0]      dv_neg, dv_nz;
  logic            dv_deg;

  // Output stage.
  logic [W-1:0] lane [3];
  logic [W-1:0] pivot;
  logic [R-2:0] half_root;
  logic [W-1:0] qw_d, qx_d, qy_d, qz_d;
  logic         out_valid_q;
  logic [W-1:0] qw_q, qx_q, qy_q, qz_q;
  logic [1:0]   branch_q;
  logic         deg_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  rmq_front #(.W(W), .F(F)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .m00_i    (in_i.row0_col0),
    .m01_i    (in_i.row0_col1),
    .m02_i    (in_i.row0_col2),
    .m10_i    (in_i.row1_col0),
    .m11_i    (in_i.row1_col1),
    .m12_i    (in_i.row1_col2),
    .m20_i    (in_i.row2_col0),
    .m21_i    (in_i.row2_col1),
    .m22_i    (in_i.row2_col2),
    .valid_o  (fr_valid),
    .branch_o (fr_branch),
    .rad_o    (fr_rad),
    .num_o    (fr_num)
  );

  // The radicand is shifted up by FRAC_BITS so the root carries FRAC_BITS fraction bits.
  assign sq_rad     = SQI'(fr_rad) << F;
  assign sq_side_in = {fr_branch, fr_num[0], fr_num[1], fr_num[2]};

  rmq_sqrt #(.IN_BITS(SQI), .SIDE_BITS(SQSD)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (sq_rad),
    .side_i  (sq_side_in),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side_out)
  );

  assign {sq_branch, sq_num[0], sq_num[1], sq_num[2]} = sq_side_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_valid_q <= 1'b0;
    end else if (en) begin
      pp_valid_q <= sq_valid;
    end
  end

  // Split each numerator into sign and magnitude and scale the magnitude.
  // The magnitude is unsigned, so the most negative numerator widens correctly.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_root_q   <= sq_root;
      pp_branch_q <= sq_branch;
      for (int l = 0; l < 3; l++) begin
        pp_neg_q[l] <= sq_num[l][NUMW-1];
        pp_nz_q[l]  <= sq_num[l] != '0;
        pp_dvd_q[l] <= N'($unsigned(sq_num[l][NUMW-1] ? NUMW'(-sq_num[l])
                                                       : NUMW'(sq_num[l]))) << F;
      end
    end
  end

  rmq_div #(.N(N), .D(D), .LANES(3), .SIDE_BITS(DVSD)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (pp_valid_q),
    .dividend_i (pp_dvd_q),
    .divisor_i  ({pp_root_q, 1'b0}),
    .side_i     ({pp_root_q, pp_branch_q, pp_neg_q, pp_nz_q}),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  assign {dv_root, dv_branch, dv_neg, dv_nz} = dv_side;
  assign dv_deg = dv_root == '0;

  // Saturate each quotient and apply its sign; a zero divisor gives the extremes or zero.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_deg) begin
        lane[l] = dv_nz[l] ? (dv_neg[l] ? WMin : WMax) : '0;
      end else if (dv_quot[l] > N'(WMax)) begin
        lane[l] = dv_neg[l] ? WMin : WMax;
      end else if (dv_neg[l]) begin
        lane[l] = W'(0) - dv_quot[l][W-1:0];
      end else begin
        lane[l] = dv_quot[l][W-1:0];
      end
    end
  end

  // The pivot is the root halved, rounded down.
  assign half_root = dv_root[R-1:1];
  assign pivot     = (CW'(half_root) > CW'(WMax)) ? WMax : W'(half_root);

  always_comb begin
    unique case (dv_branch)
      BR_TRACE: begin
        qw_d = pivot;   qx_d = lane[0]; qy_d = lane[1]; qz_d = lane[2];
      end
      BR_X: begin
        qw_d = lane[0]; qx_d = pivot;   qy_d = lane[1]; qz_d = lane[2];
      end
      BR_Y: begin
        qw_d = lane[0]; qx_d = lane[1]; qy_d = pivot;   qz_d = lane[2];
      end
      default: begin
        qw_d = lane[0]; qx_d = lane[1]; qy_d = lane[2]; qz_d = pivot;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qw_q     <= qw_d;
      qx_q     <= qx_d;
      qy_q     <= qy_d;
      qz_q     <= qz_d;
      branch_q <= dv_branch;
      deg_q    <= dv_deg;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.quat_w       = qw_q;
  assign out_o.quat_x       = qx_q;
  assign out_o.quat_y       = qy_q;
  assign out_o.quat_z       = qz_q;
  assign out_o.branch_taken = branch_q;
  assign out_o.degenerate   = deg_q;

  // A positive trace gives a radicand of at least one, so never a zero divisor.
  a_deg_not_trace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && deg_q |-> branch_q != BR_TRACE)
    else $error("degenerate result on the trace branch");

  // A degenerate result has a zero pivot component.
  a_deg_pivot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && deg_q |->
      (branch_q == BR_X && qx_q == '0) || (branch_q == BR_Y && qy_q == '0) ||
      (branch_q == BR_Z && qz_q == '0))
    else $error("degenerate result with nonzero pivot");

  // The pivot component comes from a root and is never negative.
  a_pivot_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && branch_q == BR_TRACE |-> !qw_q[W-1])
    else $error("negative scalar pivot");

endmodule

// ===== hdl/rmq_front.sv =====
// Branch selection, radicand and numerator formation, one register stage.
module rmq_front import rmq_pkg::*; #(
  parameter int unsigned W    = WordBitsDef,
  parameter int unsigned F    = FracBitsDef,
  parameter int unsigned RB   = ((W > F + 1) ? W : F + 1) + 3,
  parameter int unsigned RADW = RB - 1,
  parameter int unsigned NUMW = W + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [W-1:0]    m00_i,
  input  logic signed [W-1:0]    m01_i,
  input  logic signed [W-1:0]    m02_i,
  input  logic signed [W-1:0]    m10_i,
  input  logic signed [W-1:0]    m11_i,
  input  logic signed [W-1:0]    m12_i,
  input  logic signed [W-1:0]    m20_i,
  input  logic signed [W-1:0]    m21_i,
  input  logic signed [W-1:0]    m22_i,
  output logic                   valid_o,
  output logic [1:0]             branch_o,
  output logic [RADW-1:0]        rad_o,
  output logic signed [NUMW-1:0] num_o [3]
);

  localparam logic signed [RB-1:0] One = RB'(1) << F;

  logic signed [RB-1:0]   e00, e11, e22, trace, rad;
  logic [1:0]             branch;
  logic signed [NUMW-1:0] num [3];
  logic signed [NUMW-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;

  logic                   valid_q;
  logic [1:0]             branch_q;
  logic [RADW-1:0]        rad_q;
  logic signed [NUMW-1:0] num_q [3];

  assign e00    = RB'(m00_i);
  assign e11    = RB'(m11_i);
  assign e22    = RB'(m22_i);
  assign trace  = e00 + e11 + e22;
  assign d21_12 = NUMW'(m21_i) - NUMW'(m12_i);
  assign d02_20 = NUMW'(m02_i) - NUMW'(m20_i);
  assign d10_01 = NUMW'(m10_i) - NUMW'(m01_i);
  assign s01_10 = NUMW'(m01_i) + NUMW'(m10_i);
  assign s02_20 = NUMW'(m02_i) + NUMW'(m20_i);
  assign s12_21 = NUMW'(m12_i) + NUMW'(m21_i);

  // Pick the branch and its radicand and numerators.
  always_comb begin
    if (trace > 0) begin
      branch = BR_TRACE;
      rad    = trace + One;
      num[0] = d21_12; num[1] = d02_20; num[2] = d10_01;
    end else if (m00_i > m11_i && m00_i > m22_i) begin
      branch = BR_X;
      rad    = One + e00 - e11 - e22;
      num[0] = d21_12; num[1] = s01_10; num[2] = s02_20;
    end else if (m11_i > m22_i) begin
      branch = BR_Y;
      rad    = One + e11 - e00 - e22;
      num[0] = d02_20; num[1] = s01_10; num[2] = s12_21;
    end else begin
      branch = BR_Z;
      rad    = One + e22 - e00 - e11;
      num[0] = d10_01; num[1] = s02_20; num[2] = s12_21;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // A negative radicand clamps to zero.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      branch_q <= branch;
      rad_q    <= rad[RB-1] ? '0 : rad[RADW-1:0];
      num_q    <= num;
    end
  end

  assign valid_o  = valid_q;
  assign branch_o = branch_q;
  assign rad_o    = rad_q;
  assign num_o    = num_q;

endmodule

// ===== hdl/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, floor rounding.
module rmq_sqrt #(
  parameter int unsigned IN_BITS   = 64,
  parameter int unsigned SIDE_BITS = 8,
  parameter int unsigned R         = IN_BITS / 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [IN_BITS-1:0]   rad_i,
  input  logic [SIDE_BITS-1:0] side_i,
  output logic                 valid_o,
  output logic [R-1:0]         root_o,
  output logic [SIDE_BITS-1:0] side_o
);

  localparam int unsigned RMW = R + 2;

  logic [R-1:0]         valid_q;
  logic [RMW-1:0]       rem_q  [R];
  logic [R-1:0]         root_q [R];
  logic [IN_BITS-1:0]   rad_q  [R];
  logic [SIDE_BITS-1:0] side_q [R];

  for (genvar g = 0; g < R; g++) begin : g_stage
    logic                 vin;
    logic [RMW-1:0]       rem_in;
    logic [R-1:0]         root_in;
    logic [IN_BITS-1:0]   rad_in;
    logic [SIDE_BITS-1:0] side_in;
    logic [RMW+1:0]       rem_sh, trial;
    logic                 ge;

    if (g == 0) begin : g_first
      assign vin     = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = valid_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign side_in = side_q[g-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign rem_sh = {rem_in, rad_in[IN_BITS-1 -: 2]};
    assign trial  = {RMW'(root_in), 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= ge ? RMW'(rem_sh - trial) : RMW'(rem_sh);
        root_q[g] <= {root_in[R-2:0], ge};
        rad_q[g]  <= rad_in << 2;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[R-1];
  assign root_o  = root_q[R-1];
  assign side_o  = side_q[R-1];

endmodule

// ===== hdl/rmq_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor.
module rmq_div #(
  parameter int unsigned N         = 63,
  parameter int unsigned D         = 33,
  parameter int unsigned LANES     = 3,
  parameter int unsigned SIDE_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [N-1:0]         dividend_i [LANES],
  input  logic [D-1:0]         divisor_i,
  input  logic [SIDE_BITS-1:0] side_i,
  output logic                 valid_o,
  output logic [N-1:0]         quot_o [LANES],
  output logic [SIDE_BITS-1:0] side_o
);

  logic [N-1:0]         valid_q;
  logic [D-1:0]         dsr_q  [N];
  logic [SIDE_BITS-1:0] side_q [N];
  logic [N-1:0]         dq_q   [N][LANES];
  logic [D-1:0]         rem_q  [N][LANES];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic                 vin;
    logic [D-1:0]         dsr_in;
    logic [SIDE_BITS-1:0] side_in;

    if (g == 0) begin : g_first
      assign vin     = valid_i;
      assign dsr_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = valid_q[g-1];
      assign dsr_in  = dsr_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dsr_q[g]  <= dsr_in;
        side_q[g] <= side_in;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [N-1:0] dq_in;
      logic [D-1:0] rem_in;
      logic [D:0]   r_sh;
      logic         ge;

      if (g == 0) begin : g_first
        assign dq_in  = dividend_i[l];
        assign rem_in = '0;
      end else begin : g_next
        assign dq_in  = dq_q[g-1][l];
        assign rem_in = rem_q[g-1][l];
      end

      // Shift in the next dividend bit and subtract if it fits; the
      // quotient bit enters at the bottom of the same word.
      assign r_sh = {rem_in, dq_in[N-1]};
      assign ge   = r_sh >= {1'b0, dsr_in};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g][l] <= ge ? D'(r_sh - {1'b0, dsr_in}) : D'(r_sh);
          dq_q[g][l]  <= {dq_in[N-2:0], ge};
        end
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign side_o  = side_q[N-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quot_o[l] = dq_q[N-1][l];
  end

endmodule

// ===== tb/sv/rotation_matrix_to_quaternion_tb.sv =====
module rotation_matrix_to_quaternion_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  localparam int unsigned WB = WordBitsDef;
  localparam int unsigned FB = FracBitsDef;
  localparam longint WMAX = (64'sd1 <<< (WB - 1)) - 1;
  localparam longint WMIN = -WMAX - 1;
  localparam int IdleLimit = 20000;
  localparam int NumRandom = 1200;

  typedef struct packed {
    logic signed [WB-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  typedef struct packed {
    logic signed [WB-1:0] w, x, y, z;
    logic [1:0]           branch;
    logic                 degenerate;
  } quat_t;

  // Integer square root, rounded down, bit by bit.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // Fixed-point quotient truncated toward zero, saturated to the word.
  function automatic longint fixed_div(longint num, longint unsigned s);
    longint unsigned mag, q;
    if (s == 0) return num > 0 ? WMAX : (num < 0 ? WMIN : 0);
    mag = num < 0 ? longint'(-num) : longint'(num);
    q = (mag << FB) / s;
    if (num >= 0) return q > longint'(WMAX) ? WMAX : longint'(q);
    return q > longint'(WMAX) ? WMIN : -longint'(q);
  endfunction

  function automatic quat_t predict_quaternion(matrix_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint one, trace, rad;
    longint nums[3];
    longint q[4];
    longint unsigned root, s, p;
    logic [1:0] br;
    int k;
    quat_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    one = 64'sd1 <<< FB;
    trace = a00 + a11 + a22;
    if (trace > 0) begin
      br = BR_TRACE; rad = trace + one;
      nums[0] = a21 - a12; nums[1] = a02 - a20; nums[2] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      br = BR_X; rad = one + a00 - a11 - a22;
      nums[0] = a21 - a12; nums[1] = a01 + a10; nums[2] = a02 + a20;
    end else if (a11 > a22) begin
      br = BR_Y; rad = one + a11 - a00 - a22;
      nums[0] = a02 - a20; nums[1] = a01 + a10; nums[2] = a12 + a21;
    end else begin
      br = BR_Z; rad = one + a22 - a00 - a11;
      nums[0] = a10 - a01; nums[1] = a02 + a20; nums[2] = a12 + a21;
    end
    if (rad < 0) rad = 0;
    root = floor_sqrt(longint'(rad) << FB);
    s = root << 1;
    k = 0;
    for (int i = 0; i < 4; i++) begin
      if (i == int'(br)) begin
        p = root >> 1;
        q[i] = p > longint'(WMAX) ? WMAX : longint'(p);
      end else begin
        q[i] = fixed_div(nums[k], s);
        k++;
      end
    end
    r.w = q[0][WB-1:0]; r.x = q[1][WB-1:0]; r.y = q[2][WB-1:0]; r.z = q[3][WB-1:0];
    r.branch = br;
    r.degenerate = (s == 0);
    return r;
  endfunction

  // Scoreboard: holds predicted quaternions in request order.
  class quat_scoreboard;
    quat_t pending_quats[$];
    int    mismatches;

    function void note_matrix(matrix_t m);
      pending_quats.push_back(predict_quaternion(m));
    endfunction

    function void check_quat(quat_t got);
      quat_t exp_q;
      if (pending_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_q = pending_quats.pop_front();
      if (got !== exp_q) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_q, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  rmq_in_if  #(.W(WB)) in_ch ();
  rmq_out_if #(.W(WB)) out_ch ();

  rotation_matrix_to_quaternion u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  quat_scoreboard sb;
  bit  calm_phase;
  int  idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Note accepted requests and check results on each edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_matrix({in_ch.row0_col0, in_ch.row0_col1, in_ch.row0_col2,
                        in_ch.row1_col0, in_ch.row1_col1, in_ch.row1_col2,
                        in_ch.row2_col0, in_ch.row2_col1, in_ch.row2_col2});
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_quat({out_ch.quat_w, out_ch.quat_x, out_ch.quat_y, out_ch.quat_z,
                       out_ch.branch_taken, out_ch.degenerate});
      end
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stalls in random bursts, none in the calm phase.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  task automatic send_matrix(matrix_t m);
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.row0_col0, in_ch.row0_col1, in_ch.row0_col2,
     in_ch.row1_col0, in_ch.row1_col1, in_ch.row1_col2,
     in_ch.row2_col0, in_ch.row2_col1, in_ch.row2_col2} <= m;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic logic [WB-1:0] any_word();
    case ($urandom_range(0, 5))
      0: return WMAX[WB-1:0];
      1: return WMIN[WB-1:0];
      2: return '0;
      3: return $urandom_range(0, 2 ** 31 - 1);
      default: return $urandom();
    endcase
  endfunction

  // Near-rotation entries: magnitude at most about one, with a random pivot.
  function automatic matrix_t random_rotation_like();
    matrix_t m;
    logic signed [WB-1:0] one;
    one = 1 << FB;
    m = '0;
    m.m01 = $signed($urandom_range(0, 2 ** 31 - 1)) - (2 ** 30);
    m.m02 = $signed($urandom_range(0, 2 ** 31 - 1)) - (2 ** 30);
    m.m10 = $signed($urandom_range(0, 2 ** 31 - 1)) - (2 ** 30);
    m.m12 = $signed($urandom_range(0, 2 ** 31 - 1)) - (2 ** 30);
    m.m20 = $signed($urandom_range(0, 2 ** 31 - 1)) - (2 ** 30);
    m.m21 = $signed($urandom_range(0, 2 ** 31 - 1)) - (2 ** 30);
    m.m00 = $signed($urandom_range(0, 2 ** 31 - 1)) - (2 ** 30);
    m.m11 = $signed($urandom_range(0, 2 ** 31 - 1)) - (2 ** 30);
    m.m22 = $signed($urandom_range(0, 2 ** 31 - 1)) - (2 ** 30);
    // Push the trace negative often so all pivot branches are hit.
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 2))
        0: begin m.m00 = one - $urandom_range(0, 1000); m.m11 = -m.m11[WB-1] ? m.m11 : -m.m11;
                 m.m22 = -one; end
        1: begin m.m11 = one - $urandom_range(0, 1000); m.m00 = -one; m.m22 = -one + 5; end
        default: begin m.m22 = one; m.m00 = -one; m.m11 = -one + $urandom_range(0, 100); end
      endcase
    end
    return m;
  endfunction

  initial begin
    matrix_t m;
    logic signed [WB-1:0] one;
    one = 1 << FB;
    sb = new();
    calm_phase = 1'b0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.row0_col0, in_ch.row0_col1, in_ch.row0_col2,
     in_ch.row1_col0, in_ch.row1_col1, in_ch.row1_col2,
     in_ch.row2_col0, in_ch.row2_col1, in_ch.row2_col2} = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, each pivot, and extremes.
    send_matrix({one, 32'sd0, 32'sd0, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0, one});
    send_matrix({one, 32'sd0, 32'sd0, 32'sd0, -one, 32'sd0, 32'sd0, 32'sd0, -one});
    send_matrix({-one, 32'sd0, 32'sd0, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0, -one});
    send_matrix({-one, 32'sd0, 32'sd0, 32'sd0, -one, 32'sd0, 32'sd0, 32'sd0, one});
    // Numerators of every sign, and the zero matrix.
    send_matrix({-one, 32'sd5, -32'sd7, 32'sd3, -one, 32'sd0, 32'sd7, 32'sd1, -one});
    send_matrix({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    // Y pivot with a negative trace.
    send_matrix({-one, 32'sd9, 32'sd1, -32'sd4, -one, 32'sd2, 32'sd3, 32'sd8, -(one <<< 1)});
    // X pivot with extreme off-diagonal entries.
    send_matrix({-one + 1, WMAX[WB-1:0], WMIN[WB-1:0], WMIN[WB-1:0], -one, WMAX[WB-1:0],
                 WMAX[WB-1:0], WMIN[WB-1:0], -one});
    m = {9{WMAX[WB-1:0]}}; send_matrix(m);
    m = {9{WMIN[WB-1:0]}}; send_matrix(m);
    m = {9{32'hFFFF_FFFF}}; send_matrix(m);
    m = {9{32'h5555_5555}}; send_matrix(m);
    m = {9{32'hAAAA_AAAA}}; send_matrix(m);
    // Ties on the diagonal with non-positive trace.
    send_matrix({-one, 32'sd1, 32'sd2, 32'sd3, -one, 32'sd4, 32'sd5, 32'sd6, -one});
    send_matrix({32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd0, 32'sd4, 32'sd5, 32'sd6, -one});

    // Hold off until everything sent so far has come back.
    in_ch.valid <= 1'b0;
    while (sb.pending_quats.size() != 0) @(posedge clk_i);

    for (int i = 0; i < NumRandom; i++) begin
      if (i >= NumRandom - 150) calm_phase = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        m = random_rotation_like();
      end else begin
        m = {any_word(), any_word(), any_word(), any_word(), any_word(),
             any_word(), any_word(), any_word(), any_word()};
      end
      send_matrix(m);
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_quats.size() != 0) @(posedge clk_i);
    repeat (2 * WB + 2 * FB + 10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_quats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== rotation_matrix_to_quaternion.f =====
hdl/rmq_pkg.sv
hdl/rmq_if.sv
hdl/rmq_front.sv
hdl/rmq_sqrt.sv
hdl/rmq_div.sv
hdl/rotation_matrix_to_quaternion.sv
tb/sv/rotation_matrix_to_quaternion_tb.sv
